>>> rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [2:0] {
        FUNC_PUSH_TAIL    = 3'd0,
        FUNC_PUSH_HEAD    = 3'd1,
        FUNC_POP_HEAD     = 3'd2,
        FUNC_POP_TAIL     = 3'd3,
        FUNC_CLEAR        = 3'd4,
        FUNC_CURSOR_FIRST = 3'd5,
        FUNC_CURSOR_NEXT  = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0] func;
        t_word      data_word;
    } t_item;

    typedef struct packed {
        t_word      data_out;
        logic [1:0] status;
        t_cnt       count;
        t_word      head_word;
        t_word      tail_word;
    } t_result;

    function automatic t_slot slot_inc(input t_slot s);
        return (s == t_slot'(DEPTH - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        return (s == '0) ? t_slot'(DEPTH - 1) : t_slot'(s - 1'b1);
    endfunction

    // head plus an offset of at most DEPTH, wrapped once
    function automatic t_slot slot_add(input t_slot s, input t_cnt off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(s) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return t_slot'(sum);
    endfunction

endpackage

>>> rtl/double_ended_queue.sv
// Bounded double-ended queue over a ring of DEPTH words. One command is taken on every
// clock in which start is high; busy stays low, so commands may follow back to back.
// Each command yields exactly one result beat on o_result, marked by o_strobe, in the clock
// after the command was taken. The receiver cannot stall: a beat not sampled in its
// cycle is gone. The ring is a single-write, single-read memory with registered read
// data; head and tail words are kept in registers, so every command needs at most one
// ring read, which lets each result come in the cycle after its command.
module double_ended_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  deq_pkg::t_item i_item,
    output logic           o_strobe,
    output deq_pkg::t_result o_result
);
    import deq_pkg::*;

    t_word   r_ring [DEPTH];
    t_word   r_rd_data;

    t_slot   r_head, n_head;
    t_cnt    r_count, n_count;
    t_slot   r_cursor, n_cursor;
    logic    r_cursor_valid, n_cursor_valid;
    t_word   r_head_word, n_head_word;
    t_word   r_tail_word, n_tail_word;
    logic    r_head_rd, n_head_rd;
    logic    r_tail_rd, n_tail_rd;

    logic    r_valid;
    t_word   r_data, n_data;
    logic    r_data_rd, n_data_rd;
    t_status r_status, n_status;

    logic    rd_en;
    t_slot   rd_addr;
    logic    wr_en;
    t_slot   wr_addr;

    t_word   eff_head;
    t_word   eff_tail;
    t_slot   tail_slot;

    assign busy      = 1'b0;
    assign eff_head  = r_head_rd ? r_rd_data : r_head_word;
    assign eff_tail  = r_tail_rd ? r_rd_data : r_tail_word;
    assign tail_slot = slot_add(r_head, t_cnt'(r_count - 1'b1));

    always_comb begin
        n_head         = r_head;
        n_count        = r_count;
        n_cursor       = r_cursor;
        n_cursor_valid = r_cursor_valid;
        n_head_word    = eff_head;
        n_tail_word    = eff_tail;
        n_head_rd      = 1'b0;
        n_tail_rd      = 1'b0;
        n_data         = '0;
        n_data_rd      = 1'b0;
        n_status       = ST_OK;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        if (start) begin
            case (i_item.func)
                FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
                    if (i_item.data_word == '0) begin
                        n_status = ST_NULL;
                    end else if (r_count == t_cnt'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = t_cnt'(r_count + 1'b1);
                        n_data  = i_item.data_word;
                        if (i_item.func == FUNC_PUSH_TAIL) begin
                            wr_addr     = slot_add(r_head, r_count);
                            n_tail_word = i_item.data_word;
                            if (r_count == '0) begin
                                n_head_word = i_item.data_word;
                            end
                        end else begin
                            wr_addr     = slot_dec(r_head);
                            n_head      = slot_dec(r_head);
                            n_head_word = i_item.data_word;
                            if (r_count == '0) begin
                                n_tail_word = i_item.data_word;
                            end
                        end
                    end
                end
                FUNC_POP_HEAD: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_data  = eff_head;
                        n_count = t_cnt'(r_count - 1'b1);
                        n_head  = slot_inc(r_head);
                        if (r_cursor_valid && r_cursor == r_head) begin
                            n_cursor_valid = 1'b0;
                        end
                        if (r_count == t_cnt'(1)) begin
                            n_head_word = '0;
                            n_tail_word = '0;
                        end else begin
                            rd_en     = 1'b1;
                            rd_addr   = slot_inc(r_head);
                            n_head_rd = 1'b1;
                        end
                    end
                end
                FUNC_POP_TAIL: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_data  = eff_tail;
                        n_count = t_cnt'(r_count - 1'b1);
                        if (r_cursor_valid && r_cursor == tail_slot) begin
                            n_cursor_valid = 1'b0;
                        end
                        if (r_count == t_cnt'(1)) begin
                            n_head_word = '0;
                            n_tail_word = '0;
                        end else begin
                            rd_en     = 1'b1;
                            rd_addr   = slot_dec(tail_slot);
                            n_tail_rd = 1'b1;
                        end
                    end
                end
                FUNC_CLEAR: begin
                    n_count        = '0;
                    n_head         = '0;
                    n_cursor_valid = 1'b0;
                    n_head_word    = '0;
                    n_tail_word    = '0;
                end
                FUNC_CURSOR_FIRST: begin
                    if (r_count == '0) begin
                        n_cursor_valid = 1'b0;
                        n_status       = ST_EMPTY;
                    end else begin
                        n_cursor       = r_head;
                        n_cursor_valid = 1'b1;
                        n_data         = eff_head;
                    end
                end
                FUNC_CURSOR_NEXT: begin
                    if (!r_cursor_valid || r_count == '0 || r_cursor == tail_slot) begin
                        n_cursor_valid = 1'b0;
                        n_status       = ST_EMPTY;
                    end else begin
                        n_cursor  = slot_inc(r_cursor);
                        rd_en     = 1'b1;
                        rd_addr   = slot_inc(r_cursor);
                        n_data_rd = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_EMPTY;
                end
            endcase
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= i_item.data_word;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_count        <= '0;
            r_cursor       <= '0;
            r_cursor_valid <= 1'b0;
            r_head_word    <= '0;
            r_tail_word    <= '0;
            r_head_rd      <= 1'b0;
            r_tail_rd      <= 1'b0;
            r_valid        <= 1'b0;
            r_data_rd      <= 1'b0;
        end else begin
            r_head         <= n_head;
            r_count        <= n_count;
            r_cursor       <= n_cursor;
            r_cursor_valid <= n_cursor_valid;
            r_head_word    <= n_head_word;
            r_tail_word    <= n_tail_word;
            r_head_rd      <= n_head_rd;
            r_tail_rd      <= n_tail_rd;
            r_valid        <= start;
            r_data_rd      <= n_data_rd;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign o_strobe           = r_valid;
    assign o_result.data_out  = r_data_rd ? r_rd_data : r_data;
    assign o_result.status    = r_status;
    assign o_result.count     = r_count;
    assign o_result.head_word = eff_head;
    assign o_result.tail_word = eff_tail;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    import deq_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic [2:0] func;
        t_word      data;
        bit         fixed;
        t_result    res;
    } t_stim_row;

    typedef struct {
        bit      fixed;
        t_result res;
    } t_typed_hint;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    logic    o_strobe;
    t_result o_result;

    double_ended_queue uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // deque shadow state
    t_word mdl_ring [DEPTH];
    int    mdl_head   = 0;
    int    mdl_count  = 0;
    int    mdl_cur    = 0;
    bit    mdl_cur_ok = 1'b0;

    t_result     pending_results [$];
    t_typed_hint typed_hints [$];
    t_stim_row   directed_rows [$];

    int  mismatches  = 0;
    int  cycles      = 0;
    int  beats_seen  = 0;
    int  n_ok        = 0;
    int  n_empty     = 0;
    int  n_full      = 0;
    int  n_null      = 0;
    int  peak_count  = 0;
    bit  idle_en     = 1'b1;

    function automatic t_result mk_res(input t_word d, input t_status st, input int c,
                                       input t_word h, input t_word t);
        t_result r;
        r.data_out  = d;
        r.status    = st;
        r.count     = t_cnt'(c);
        r.head_word = h;
        r.tail_word = t;
        return r;
    endfunction

    function automatic int tail_slot_of();
        return (mdl_head + mdl_count - 1) % DEPTH;
    endfunction

    function automatic t_result deque_apply(input t_item it);
        t_result r;
        int      s;
        r = '0;
        r.status = ST_OK;
        case (it.func)
            FUNC_PUSH_TAIL, FUNC_PUSH_HEAD: begin
                if (it.data_word == '0) begin
                    r.status = ST_NULL;
                end else if (mdl_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (it.func == FUNC_PUSH_TAIL) begin
                        s = (mdl_head + mdl_count) % DEPTH;
                    end else begin
                        mdl_head = (mdl_head + DEPTH - 1) % DEPTH;
                        s = mdl_head;
                    end
                    mdl_ring[s] = it.data_word;
                    mdl_count++;
                    r.data_out = it.data_word;
                end
            end
            FUNC_POP_HEAD, FUNC_POP_TAIL: begin
                if (mdl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = (it.func == FUNC_POP_HEAD) ? mdl_head : tail_slot_of();
                    r.data_out = mdl_ring[s];
                    if (mdl_cur_ok && mdl_cur == s) begin
                        mdl_cur_ok = 1'b0;
                    end
                    if (it.func == FUNC_POP_HEAD) begin
                        mdl_head = (mdl_head + 1) % DEPTH;
                    end
                    mdl_count--;
                end
            end
            FUNC_CLEAR: begin
                mdl_count  = 0;
                mdl_head   = 0;
                mdl_cur_ok = 1'b0;
            end
            FUNC_CURSOR_FIRST: begin
                if (mdl_count == 0) begin
                    mdl_cur_ok = 1'b0;
                    r.status = ST_EMPTY;
                end else begin
                    mdl_cur    = mdl_head;
                    mdl_cur_ok = 1'b1;
                    r.data_out = mdl_ring[mdl_head];
                end
            end
            FUNC_CURSOR_NEXT: begin
                if (!mdl_cur_ok || mdl_count == 0) begin
                    mdl_cur_ok = 1'b0;
                    r.status = ST_EMPTY;
                end else if (mdl_cur == tail_slot_of()) begin
                    mdl_cur_ok = 1'b0;
                    r.status = ST_EMPTY;
                end else begin
                    mdl_cur = (mdl_cur + 1) % DEPTH;
                    r.data_out = mdl_ring[mdl_cur];
                end
            end
            default: begin
                r.status = ST_EMPTY;
            end
        endcase
        r.count = t_cnt'(mdl_count);
        if (mdl_count != 0) begin
            r.head_word = mdl_ring[mdl_head];
            r.tail_word = mdl_ring[tail_slot_of()];
        end
        if (mdl_count > peak_count) begin
            peak_count = mdl_count;
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [63:0] exp_v,
                                input logic [63:0] got_v);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
        end
        mismatches++;
    endtask

    // accept, predict and check on every edge
    always @(posedge i_clk) begin
        t_result     pred_r;
        t_result     exp_r;
        t_typed_hint hint;
        if (i_rst_n && start && !busy) begin
            pred_r = deque_apply(i_item);
            hint.fixed = 1'b0;
            if (typed_hints.size() != 0) begin
                hint = typed_hints.pop_front();
            end
            pending_results.push_back(hint.fixed ? hint.res : pred_r);
        end
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result beat with nothing pending", '0,
                             64'(o_result.data_out));
            end else begin
                exp_r = pending_results.pop_front();
                beats_seen++;
                if (o_result.data_out !== exp_r.data_out)
                    log_mismatch("data_out", 64'(exp_r.data_out), 64'(o_result.data_out));
                if (o_result.status !== exp_r.status)
                    log_mismatch("status", 64'(exp_r.status), 64'(o_result.status));
                if (o_result.count !== exp_r.count)
                    log_mismatch("count", 64'(exp_r.count), 64'(o_result.count));
                if (o_result.head_word !== exp_r.head_word)
                    log_mismatch("head_word", 64'(exp_r.head_word),
                                 64'(o_result.head_word));
                if (o_result.tail_word !== exp_r.tail_word)
                    log_mismatch("tail_word", 64'(exp_r.tail_word),
                                 64'(o_result.tail_word));
                case (exp_r.status)
                    ST_OK:    n_ok++;
                    ST_EMPTY: n_empty++;
                    ST_FULL:  n_full++;
                    default:  n_null++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats pending", cycles,
                     pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drive_item(input logic [2:0] func, input t_word data);
        t_item it;
        it.func      = func;
        it.data_word = data;
        while (idle_en && $urandom_range(99) < 11) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [2:0] func, input t_word data, input bit fixed,
                           input t_result res);
        t_stim_row row;
        row.func  = func;
        row.data  = data;
        row.fixed = fixed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    function automatic t_word rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) return '0;
        if (pick < 7) return '1;
        return t_word'($urandom);
    endfunction

    function automatic logic [2:0] rand_func(input int mode);
        int p;
        p = $urandom_range(99);
        case (mode)
            0: begin
                if (p < 40) return FUNC_PUSH_TAIL;
                if (p < 70) return FUNC_PUSH_HEAD;
                if (p < 80) return FUNC_POP_HEAD;
                if (p < 88) return FUNC_POP_TAIL;
                if (p < 92) return FUNC_CURSOR_FIRST;
                if (p < 99) return FUNC_CURSOR_NEXT;
                return FUNC_CLEAR;
            end
            1: begin
                if (p < 15) return FUNC_PUSH_TAIL;
                if (p < 25) return FUNC_PUSH_HEAD;
                if (p < 55) return FUNC_POP_HEAD;
                if (p < 85) return FUNC_POP_TAIL;
                if (p < 90) return FUNC_CURSOR_FIRST;
                if (p < 99) return FUNC_CURSOR_NEXT;
                return FUNC_CLEAR;
            end
            2: begin
                if (p < 10) return FUNC_PUSH_TAIL;
                if (p < 20) return FUNC_PUSH_HEAD;
                if (p < 27) return FUNC_POP_HEAD;
                if (p < 34) return FUNC_POP_TAIL;
                if (p < 45) return FUNC_CURSOR_FIRST;
                if (p < 99) return FUNC_CURSOR_NEXT;
                return FUNC_CLEAR;
            end
            default: begin
                if (p < 20) return FUNC_PUSH_TAIL;
                if (p < 40) return FUNC_PUSH_HEAD;
                if (p < 55) return FUNC_POP_HEAD;
                if (p < 70) return FUNC_POP_TAIL;
                if (p < 78) return FUNC_CURSOR_FIRST;
                if (p < 96) return FUNC_CURSOR_NEXT;
                return FUNC_CLEAR;
            end
        endcase
    endfunction

    initial begin
        t_result     none_empty;
        t_result     none_null;
        t_typed_hint hint;
        int          mode;

        none_empty = mk_res('0, ST_EMPTY, 0, '0, '0);
        none_null  = mk_res('0, ST_NULL, 0, '0, '0);

        // empty store, null words, extremes, cursor walk and removal, clear, wrap
        add_row(FUNC_POP_HEAD,     '0,           1, none_empty);
        add_row(FUNC_POP_TAIL,     '0,           1, none_empty);
        add_row(FUNC_CURSOR_FIRST, '0,           1, none_empty);
        add_row(FUNC_CURSOR_NEXT,  '0,           1, none_empty);
        add_row(FUNC_PUSH_TAIL,    '0,           1, none_null);
        add_row(FUNC_PUSH_HEAD,    '0,           1, none_null);
        add_row(FUNC_PUSH_TAIL,    '1,           1,
                mk_res('1, ST_OK, 1, '1, '1));
        add_row(FUNC_PUSH_HEAD,    32'h1,        1,
                mk_res(32'h1, ST_OK, 2, 32'h1, '1));
        add_row(FUNC_CURSOR_FIRST, '0,           0, '0);
        add_row(FUNC_CURSOR_NEXT,  '0,           0, '0);
        add_row(FUNC_CURSOR_NEXT,  '0,           0, '0);
        add_row(FUNC_PUSH_TAIL,    32'hAAAA5555, 0, '0);
        add_row(FUNC_PUSH_HEAD,    32'h5555AAAA, 0, '0);
        add_row(FUNC_CURSOR_FIRST, '0,           0, '0);
        add_row(FUNC_POP_HEAD,     '0,           0, '0);
        add_row(FUNC_CURSOR_NEXT,  '0,           0, '0);
        add_row(FUNC_CURSOR_FIRST, '0,           0, '0);
        add_row(FUNC_CURSOR_NEXT,  '0,           0, '0);
        add_row(FUNC_POP_TAIL,     '0,           0, '0);
        add_row(FUNC_POP_TAIL,     '0,           0, '0);
        add_row(FUNC_PUSH_TAIL,    '0,           0, '0);
        add_row(FUNC_CLEAR,        32'hFFFF0000, 1,
                mk_res('0, ST_OK, 0, '0, '0));
        add_row(FUNC_CURSOR_NEXT,  '0,           1, none_empty);
        add_row(FUNC_PUSH_HEAD,    32'h80000000, 1,
                mk_res(32'h80000000, ST_OK, 1, 32'h80000000, 32'h80000000));
        add_row(FUNC_POP_TAIL,     '0,           1,
                mk_res(32'h80000000, ST_OK, 0, '0, '0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            hint.fixed = directed_rows[k].fixed;
            hint.res   = directed_rows[k].res;
            typed_hints.push_back(hint);
            drive_item(directed_rows[k].func, directed_rows[k].data);
        end

        mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n != 0 && n % 50 == 0) begin
                mode = $urandom_range(3);
            end
            idle_en = !(n >= 500 && n < 800);
            hint.fixed = 1'b0;
            hint.res   = '0;
            typed_hints.push_back(hint);
            drive_item(rand_func(mode), rand_word());
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("checked %0d result beats: %0d ok, %0d empty, %0d full, %0d null refused",
                 beats_seen, n_ok, n_empty, n_full, n_null);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_count, DEPTH, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/deq_pkg.sv
rtl/double_ended_queue.sv
verif/tb.sv
